[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked assertions with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define GIS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// The condition must never be seen at a rising edge outside reset.
`define GIS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[design/gis_pkg.sv]
// ----------------------------------------------------------------------------
// Grid interval search package
// Field widths, reset values and operation codes shared by the block.
// ----------------------------------------------------------------------------
package gis_pkg;

    localparam int POINTS_MAX_DEF = 256;

    localparam int INDEX_W    = 8;
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 9;
    localparam int INTERVAL_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } gis_op_t;

endpackage

[design/gis_if.sv]
// ----------------------------------------------------------------------------
// Grid interval search channels
// Valid/ready channels for requests, results and the point count register.
// ----------------------------------------------------------------------------
interface gis_req_if;
    import gis_pkg::*;

    logic                       valid;
    logic                       ready;
    gis_op_t                    operation;
    logic [INDEX_W-1:0]         point_index;
    logic signed [VALUE_W-1:0]  point_value;
    logic signed [VALUE_W-1:0]  query_value;

    modport source (
        output valid, operation, point_index, point_value, query_value,
        input  ready
    );
    modport sink (
        input  valid, operation, point_index, point_value, query_value,
        output ready
    );
endinterface

interface gis_rsp_if;
    import gis_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [INTERVAL_W-1:0]  interval_index;

    modport source (
        output valid, interval_index,
        input  ready
    );
    modport sink (
        input  valid, interval_index,
        output ready
    );
endinterface

interface gis_cfg_if;
    import gis_pkg::*;

    logic                valid;
    logic                ready;
    logic [COUNT_W-1:0]  point_count;

    modport source (
        output valid, point_count,
        input  ready
    );
    modport sink (
        input  valid, point_count,
        output ready
    );
endinterface

[design/grid_interval_search.sv]
// ----------------------------------------------------------------------------
// Grid interval search
// Pipelined binary search of a query over a table of ascending grid points.
// ----------------------------------------------------------------------------
// One request beat enters per cycle unless rsp.ready low backs the pipeline
// up to its entry; a lookup result leaves the last stage, and write beats
// take a slot in the same pipeline and give no result. Each search level is
// one pipeline stage with its own copy of the table, so every stage reads
// one point per cycle; a write beat updates each copy as it passes that
// stage, so a lookup sees exactly the writes that entered before it. The
// table holds no reset value: a lookup must touch only points that were
// written. The user must write the point count register only while the
// pipeline is empty; the block does not check. Counts clamp to 2..POINTS_MAX.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_interval_search #(
    parameter int POINTS_MAX = gis_pkg::POINTS_MAX_DEF
) (
    input logic        clk,
    input logic        rst_n,
    gis_req_if.sink    req,
    gis_rsp_if.source  rsp,
    gis_cfg_if.sink    cfg
);
    import gis_pkg::*;

    localparam int IDX_W  = $clog2(POINTS_MAX);
    localparam int CNT_W  = $clog2(POINTS_MAX + 1);
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int SLOT_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int LEVELS = IDX_W;
    localparam int LAST   = LEVELS + 1;

    typedef struct packed {
        gis_op_t             op;
        logic                keep;
        logic [IDX_W-1:0]    waddr;
        logic [VALUE_W-1:0]  data;
        logic [CNT_W-1:0]    lo;
        logic [CNT_W-1:0]    hi;
    } stage_t;

    logic [COUNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]    used_n;

    logic [LAST+1:1]     take;
    logic [LAST:1]       valid_reg;
    logic [LAST:1]       valid_next;
    stage_t              stage_reg  [1:LAST];
    stage_t              stage_next [1:LAST];
    stage_t              in_stage;

    logic [CNT_W-1:0]    lo_nx  [1:LEVELS];
    logic [CNT_W-1:0]    hi_nx  [1:LEVELS];
    logic [CNT_W-1:0]    nx_mid [1:LEVELS];

    logic                ram_we    [0:LEVELS-1];
    logic [IDX_W-1:0]    ram_waddr [0:LEVELS-1];
    logic [VALUE_W-1:0]  ram_wdata [0:LEVELS-1];
    logic                ram_re    [0:LEVELS-1];
    logic [IDX_W-1:0]    ram_raddr [0:LEVELS-1];
    logic [VALUE_W-1:0]  pmid      [0:LEVELS-1];

    logic [VALUE_W-1:0]  p_first;
    logic [VALUE_W-1:0]  p_last;
    logic                in_we;

    // ------------------------------------------------------------------
    // Point count register
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (cfg.valid)
        begin
            count_reg <= cfg.point_count;
        end
    end

    always_comb
    begin
        priority if (CMP_W'(count_reg) > CMP_W'(POINTS_MAX))
        begin
            used_n = CNT_W'(POINTS_MAX);
        end
        else if (CMP_W'(count_reg) < CMP_W'(2))
        begin
            used_n = CNT_W'(2);
        end
        else
        begin
            used_n = CNT_W'(count_reg);
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or drains.
    // ------------------------------------------------------------------
    always_comb
    begin
        take[LAST+1] = rsp.ready;
        for (int k = LAST; k >= 1; k--)
        begin
            take[k] = !valid_reg[k] || take[k+1];
        end
    end

    assign req.ready = take[1];

    // ------------------------------------------------------------------
    // Request entry
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stage.op    = req.operation;
        in_stage.keep  = SLOT_W'(req.point_index) < SLOT_W'(POINTS_MAX);
        in_stage.waddr = IDX_W'(req.point_index);
        in_stage.data  = (req.operation == OP_LOOKUP) ? req.query_value
                                                      : req.point_value;
        in_stage.lo    = '0;
        in_stage.hi    = used_n;
    end

    assign in_we = req.valid && take[1] && (req.operation == OP_WRITE) && in_stage.keep;

    // ------------------------------------------------------------------
    // Search levels. The first level splits at the midpoint rounded up,
    // the later ones round down. The first level also clamps queries that
    // fall at or outside the table ends to a one-wide interval, which the
    // remaining levels leave untouched.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [CNT_W:0]    sum;
        logic [CNT_W-1:0]  mid;
        logic [CNT_W:0]    nsum;
        for (int k = 1; k <= LEVELS; k++)
        begin
            sum = {1'b0, stage_reg[k].lo} + {1'b0, stage_reg[k].hi}
                + ((k == 1) ? (CNT_W+1)'(1) : (CNT_W+1)'(0));
            mid = CNT_W'(sum >> 1);
            lo_nx[k] = stage_reg[k].lo;
            hi_nx[k] = stage_reg[k].hi;
            if ((stage_reg[k].hi - stage_reg[k].lo) > CNT_W'(1))
            begin
                if ($signed(stage_reg[k].data) < $signed(pmid[k-1]))
                begin
                    hi_nx[k] = mid;
                end
                else
                begin
                    lo_nx[k] = mid;
                end
            end
            if (k == 1)
            begin
                priority if ($signed(stage_reg[k].data) <= $signed(p_first))
                begin
                    lo_nx[k] = '0;
                    hi_nx[k] = CNT_W'(1);
                end
                else if ($signed(stage_reg[k].data) >= $signed(p_last))
                begin
                    lo_nx[k] = used_n - CNT_W'(2);
                    hi_nx[k] = used_n - CNT_W'(1);
                end
                else
                begin
                    // Interior queries keep the search step above.
                end
            end
            nsum = {1'b0, lo_nx[k]} + {1'b0, hi_nx[k]};
            nx_mid[k] = CNT_W'(nsum >> 1);
        end
    end

    always_comb
    begin
        stage_next[1] = in_stage;
        valid_next[1] = req.valid;
        for (int k = 2; k <= LAST; k++)
        begin
            stage_next[k]    = stage_reg[k-1];
            stage_next[k].lo = lo_nx[k-1];
            stage_next[k].hi = hi_nx[k-1];
            valid_next[k]    = valid_reg[k-1];
        end
        // Write beats leave the pipeline once every table copy has seen them.
        stage_next[LAST].lo = nx_mid[LEVELS];
        valid_next[LAST]    = valid_reg[LAST-1] && (stage_reg[LAST-1].op == OP_LOOKUP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= LAST; k++)
            begin
                if (take[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= LAST; k++)
        begin
            if (take[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Table copies: one per search level plus the two table ends.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [CNT_W:0] first_sum;
        first_sum    = {1'b0, used_n} + (CNT_W+1)'(1);
        ram_we[0]    = in_we;
        ram_waddr[0] = in_stage.waddr;
        ram_wdata[0] = req.point_value;
        ram_re[0]    = take[1];
        ram_raddr[0] = IDX_W'(first_sum >> 1);
        for (int k = 1; k < LEVELS; k++)
        begin
            ram_we[k]    = take[k+1] && valid_reg[k] && (stage_reg[k].op == OP_WRITE)
                           && stage_reg[k].keep;
            ram_waddr[k] = stage_reg[k].waddr;
            ram_wdata[k] = stage_reg[k].data;
            ram_re[k]    = take[k+1];
            ram_raddr[k] = IDX_W'(nx_mid[k]);
        end
    end

    for (genvar g = 0; g < LEVELS; g++)
    begin : g_level_ram
        gis_ram #(
            .WIDTH (VALUE_W),
            .DEPTH (POINTS_MAX)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[g]),
            .waddr (ram_waddr[g]),
            .wdata (ram_wdata[g]),
            .re    (ram_re[g]),
            .raddr (ram_raddr[g]),
            .rdata (pmid[g])
        );
    end

    gis_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (POINTS_MAX)
    ) u_first_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (in_stage.waddr),
        .wdata (req.point_value),
        .re    (take[1]),
        .raddr ('0),
        .rdata (p_first)
    );

    gis_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (POINTS_MAX)
    ) u_last_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (in_stage.waddr),
        .wdata (req.point_value),
        .re    (take[1]),
        .raddr (IDX_W'(used_n - CNT_W'(1))),
        .rdata (p_last)
    );

    // ------------------------------------------------------------------
    // Result
    // ------------------------------------------------------------------
    assign rsp.valid          = valid_reg[LAST];
    assign rsp.interval_index = INTERVAL_W'(stage_reg[LAST].lo);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `GIS_ASSERT(a_bounds_ordered, clk, rst_n,
        valid_reg[LEVELS] && (stage_reg[LEVELS].op == OP_LOOKUP) |->
            stage_reg[LEVELS].lo < stage_reg[LEVELS].hi,
        "search bounds crossed inside the pipeline")
    `GIS_ASSERT_NEVER(a_search_converged, clk, rst_n,
        valid_reg[LEVELS] && (stage_reg[LEVELS].op == OP_LOOKUP)
            && ((hi_nx[LEVELS] - lo_nx[LEVELS]) != CNT_W'(1)),
        "search did not narrow to one interval in the last level")
    `GIS_ASSERT(a_stalled_stage_holds, clk, rst_n,
        valid_reg[1] && !take[2] |=> valid_reg[1] && $stable(stage_reg[1]),
        "stalled beat in the first stage was lost or changed")
endmodule

[design/gis_ram.sv]
// ----------------------------------------------------------------------------
// Grid interval search RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic [WIDTH-1:0]          wdata,
    input  logic                      re,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
